// ===== rtl/gbn_pkg.sv =====
// shared types and constants of the go-back-n sender
// no dependencies

package gbn_pkg;

  localparam int WINDOW  = 7;
  localparam int MAX_OUT = 8;
  localparam int EFF_WIN = (WINDOW < 1) ? 1 : ((WINDOW > MAX_OUT) ? MAX_OUT : WINDOW);
  localparam logic [15:0] EFF_WIN16 = 16'(EFF_WIN);

  localparam logic [7:0] ACK_FLAG    = 8'h02;
  localparam logic [7:0] TIMEOUT_RST = 8'd5;
  localparam logic [7:0] IDLE_MAX    = 8'hFF;

  localparam logic [0:0] REG_TOTAL   = 1'b0;
  localparam logic [0:0] REG_TIMEOUT = 1'b1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_ACK   = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CMD_SEND   = 2'd0,
    CMD_RESEND = 2'd1,
    CMD_TERM   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_ACK   = 2'd1,
    OP_TICK  = 2'd2
  } op_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_FILL   = 2'd1,
    ST_RESEND = 2'd2
  } state_e;

  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] seq;
  } op_t;

  typedef struct packed {
    logic [15:0] total_packets;
    logic [7:0]  timeout_ticks;
  } cfg_t;

endpackage

// ===== rtl/go_back_n_sender.sv =====
// go-back-n sender top level: config registers, front, queue and back
// depends on gbn_pkg, gbn_front, gbn_queue, gbn_back
// a terminate is written to the output register when its item is popped, a first send or resend
// from FILL or RESEND; one result per cycle while the receiver is ready, items pop only in idle
// a timeout emits up to 7 resends, a start or ack up to 7 sends, the queue holds 2 items
// reset clears window, timer and done flag; total_packets to 0, timeout_ticks to 5

module go_back_n_sender (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  ack_flag_i,
  input  logic [7:0]  ack_seq_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  command_o,
  output logic [15:0] packet_index_o,
  output logic        last_o
);

  gbn_pkg::cfg_t cfg_q;
  gbn_pkg::op_t  push_op, head_op;
  logic          push, pop, q_full, q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.total_packets <= '0;
      cfg_q.timeout_ticks <= gbn_pkg::TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gbn_pkg::REG_TOTAL: begin
          cfg_q.total_packets <= cfg_data_i;
        end
        gbn_pkg::REG_TIMEOUT: begin
          cfg_q.timeout_ticks <= cfg_data_i[7:0];
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  gbn_front u_front (
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .ack_flag_i (ack_flag_i),
    .ack_seq_i  (ack_seq_i),
    .q_full_i   (q_full),
    .in_ready_o (in_ready_o),
    .push_o     (push),
    .op_o       (push_op)
  );

  gbn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .pop_i   (pop),
    .op_o    (head_op),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  gbn_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_empty_i      (q_empty),
    .op_i           (head_op),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .command_o      (command_o),
    .packet_index_o (packet_index_o),
    .last_o         (last_o)
  );

endmodule

// ===== rtl/gbn_front.sv =====
// front end: decodes input items and drops those that can never act
// depends on gbn_pkg

module gbn_front (
  input  logic             in_valid_i,
  input  logic [1:0]       func_i,
  input  logic [7:0]       ack_flag_i,
  input  logic [7:0]       ack_seq_i,
  input  logic             q_full_i,
  output logic             in_ready_o,
  output logic             push_o,
  output gbn_pkg::op_t     op_o
);

  logic keep;

  assign in_ready_o = !q_full_i;

  always_comb begin
    keep      = 1'b0;
    op_o.seq  = ack_seq_i;
    op_o.kind = gbn_pkg::OP_TICK;
    case (gbn_pkg::func_e'(func_i))
      gbn_pkg::FUNC_START: begin
        keep      = 1'b1;
        op_o.kind = gbn_pkg::OP_START;
      end
      gbn_pkg::FUNC_ACK: begin
        keep      = (ack_flag_i == gbn_pkg::ACK_FLAG);
        op_o.kind = gbn_pkg::OP_ACK;
      end
      gbn_pkg::FUNC_TICK: begin
        keep      = 1'b1;
        op_o.kind = gbn_pkg::OP_TICK;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push_o = in_valid_i && in_ready_o && keep;

endmodule

// ===== rtl/gbn_queue.sv =====
// short queue of decoded operations between front and back
// depends on gbn_pkg

module gbn_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  gbn_pkg::op_t op_i,
  input  logic         pop_i,
  output gbn_pkg::op_t op_o,
  output logic         full_o,
  output logic         empty_o
);

  gbn_pkg::op_t                    mem_q [gbn_pkg::QDEPTH];
  logic [gbn_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [gbn_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [gbn_pkg::QCNT_W-1:0]      cnt_q, cnt_d;

  localparam logic [gbn_pkg::QPTR_W-1:0] PTR_LAST = gbn_pkg::QPTR_W'(gbn_pkg::QDEPTH - 1);
  localparam logic [gbn_pkg::QCNT_W-1:0] CNT_FULL = gbn_pkg::QCNT_W'(gbn_pkg::QDEPTH);

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign op_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) empty_o |-> !pop_i)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_FULL)
    else $error("queue count out of range");

endmodule

// ===== rtl/gbn_back.sv =====
// back end: window state, send/resend sequencer and output register
// depends on gbn_pkg

module gbn_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gbn_pkg::cfg_t cfg_i,
  input  logic          q_empty_i,
  input  gbn_pkg::op_t  op_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    command_o,
  output logic [15:0]   packet_index_o,
  output logic          last_o
);

  gbn_pkg::state_e state_q, state_d;
  logic [15:0]     base_q, base_d;
  logic [15:0]     next_q, next_d;
  logic [15:0]     cursor_q, cursor_d;
  logic [7:0]      idle_q, idle_d;
  logic            finished_q, finished_d;
  logic            out_valid_q, out_valid_d;
  gbn_pkg::cmd_e   cmd_q, cmd_d;
  logic [15:0]     idx_q, idx_d;
  logic            last_q, last_d;

  logic        load;
  logic [15:0] base_inc, next_inc, cursor_inc;
  logic [7:0]  limit, idle_inc;
  logic        outstanding, ack_good, ack_done, fill_ok_ack, tick_fire;
  logic        fill_more, resend_last;

  assign load        = !out_valid_q || out_ready_i;
  assign pop_o       = (state_q == gbn_pkg::ST_IDLE) && !q_empty_i && load;
  assign base_inc    = base_q + 16'd1;
  assign next_inc    = next_q + 16'd1;
  assign cursor_inc  = cursor_q + 16'd1;
  assign limit       = (cfg_i.timeout_ticks == 8'd0) ? 8'd1 : cfg_i.timeout_ticks;
  assign idle_inc    = (idle_q == gbn_pkg::IDLE_MAX) ? idle_q : idle_q + 8'd1;
  assign outstanding = base_q < next_q;
  assign ack_good    = !finished_q && (op_i.seq == base_q[7:0]) && outstanding;
  assign ack_done    = base_inc >= cfg_i.total_packets;
  assign fill_ok_ack = ((next_q - base_inc) < gbn_pkg::EFF_WIN16)
                       && (next_q < cfg_i.total_packets);
  assign tick_fire   = !finished_q && (idle_inc >= limit);
  assign fill_more   = ((next_inc - base_q) < gbn_pkg::EFF_WIN16)
                       && (next_inc < cfg_i.total_packets);
  assign resend_last = (cursor_inc == next_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gbn_pkg::ST_IDLE: begin
        if (pop_o) begin
          case (op_i.kind)
            gbn_pkg::OP_START: begin
              if (cfg_i.total_packets != 16'd0) begin
                state_d = gbn_pkg::ST_FILL;
              end
            end
            gbn_pkg::OP_ACK: begin
              if (ack_good && !ack_done && fill_ok_ack) begin
                state_d = gbn_pkg::ST_FILL;
              end
            end
            gbn_pkg::OP_TICK: begin
              if (tick_fire && outstanding) begin
                state_d = gbn_pkg::ST_RESEND;
              end
            end
            default: begin
              state_d = gbn_pkg::ST_IDLE;
            end
          endcase
        end
      end
      gbn_pkg::ST_FILL: begin
        if (load && !fill_more) begin
          state_d = gbn_pkg::ST_IDLE;
        end
      end
      gbn_pkg::ST_RESEND: begin
        if (load && resend_last) begin
          state_d = gbn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gbn_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and result register
  always_comb begin
    base_d      = base_q;
    next_d      = next_q;
    cursor_d    = cursor_q;
    idle_d      = idle_q;
    finished_d  = finished_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    last_d      = last_q;
    case (state_q)
      gbn_pkg::ST_IDLE: begin
        if (pop_o) begin
          case (op_i.kind)
            gbn_pkg::OP_START: begin
              base_d = '0;
              next_d = '0;
              idle_d = '0;
              finished_d = (cfg_i.total_packets == 16'd0);
              if (cfg_i.total_packets == 16'd0) begin
                out_valid_d = 1'b1;
                cmd_d       = gbn_pkg::CMD_TERM;
                idx_d       = '0;
                last_d      = 1'b1;
              end
            end
            gbn_pkg::OP_ACK: begin
              if (ack_good) begin
                base_d = base_inc;
                idle_d = '0;
                if (ack_done) begin
                  finished_d  = 1'b1;
                  out_valid_d = 1'b1;
                  cmd_d       = gbn_pkg::CMD_TERM;
                  idx_d       = '0;
                  last_d      = 1'b1;
                end
              end
            end
            gbn_pkg::OP_TICK: begin
              if (!finished_q) begin
                idle_d = tick_fire ? 8'd0 : idle_inc;
                if (tick_fire) begin
                  cursor_d = base_q;
                end
              end
            end
            default: begin
              idle_d = idle_q;
            end
          endcase
        end
      end
      gbn_pkg::ST_FILL: begin
        if (load) begin
          out_valid_d = 1'b1;
          cmd_d       = gbn_pkg::CMD_SEND;
          idx_d       = next_q;
          last_d      = !fill_more;
          next_d      = next_inc;
        end
      end
      gbn_pkg::ST_RESEND: begin
        if (load) begin
          out_valid_d = 1'b1;
          cmd_d       = gbn_pkg::CMD_RESEND;
          idx_d       = cursor_q;
          last_d      = resend_last;
          cursor_d    = cursor_inc;
        end
      end
      default: begin
        out_valid_d = out_valid_q && !out_ready_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gbn_pkg::ST_IDLE;
      base_q      <= '0;
      next_q      <= '0;
      idle_q      <= '0;
      finished_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      next_q      <= next_d;
      idle_q      <= idle_d;
      finished_q  <= finished_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cursor_q <= cursor_d;
    cmd_q    <= cmd_d;
    idx_q    <= idx_d;
    last_q   <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign command_o      = cmd_q;
  assign packet_index_o = idx_q;
  assign last_o         = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_q >= base_q) && ((next_q - base_q) <= gbn_pkg::EFF_WIN16))
    else $error("window span out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |-> (state_q == gbn_pkg::ST_IDLE))
    else $error("sequencer busy after terminate");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gbn_pkg::ST_RESEND) |-> (cursor_q >= base_q) && (cursor_q < next_q))
    else $error("resend cursor outside window");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gbn_pkg::ST_FILL) |-> (next_q < cfg_i.total_packets))
    else $error("send index beyond transfer");

endmodule

// ===== dv/testbench.sv =====
// testbench for the go-back-n sender: directed before-start, window, timeout, restart and long transfer
// tests, then random traffic; a behavioral window model predicts every command in order
// depends on gbn_pkg and go_back_n_sender

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gbn_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 10;
  localparam int RANDOM_ITEMS   = 80;

  typedef struct {
    cmd_e        cmd;
    logic [15:0] index;
    logic        last;
  } cmd_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  func_i;
  logic [7:0]  ack_flag_i;
  logic [7:0]  ack_seq_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  command_o;
  logic [15:0] packet_index_o;
  logic        last_o;

  // window model
  logic [15:0] win_total;
  logic [7:0]  win_timeout;
  logic [15:0] win_base;
  logic [15:0] win_next;
  logic [7:0]  win_idle;
  logic        win_done;
  int          emit_count;

  cmd_item_t pending_cmds[$];
  int mismatches   = 0;
  int items_sent   = 0;
  int cmds_seen    = 0;
  int stall_cycles = 0;
  int burst_left   = 0;

  go_back_n_sender dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .ack_flag_i     (ack_flag_i),
    .ack_seq_i      (ack_seq_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .command_o      (command_o),
    .packet_index_o (packet_index_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void emit_cmd(cmd_e c, logic [15:0] idx);
    if (emit_count < MAX_OUT) begin
      pending_cmds.push_back('{cmd: c, index: idx, last: 1'b0});
      emit_count++;
    end
  endfunction

  function automatic void fill_window();
    while ((win_next - win_base) < EFF_WIN16 && win_next < win_total && emit_count < MAX_OUT) begin
      emit_cmd(CMD_SEND, win_next);
      win_next++;
    end
  endfunction

  function automatic void end_transfer();
    win_done = 1'b1;
    emit_cmd(CMD_TERM, 16'd0);
  endfunction

  function automatic void window_step(func_e f, logic [7:0] flag, logic [7:0] seq);
    logic [7:0]  limit;
    logic [15:0] i;
    emit_count = 0;
    case (f)
      FUNC_START: begin
        win_base = '0;
        win_next = '0;
        win_idle = '0;
        win_done = 1'b0;
        if (win_total == 16'd0) end_transfer();
        else fill_window();
      end
      FUNC_ACK: begin
        if (!win_done && flag == ACK_FLAG && seq == win_base[7:0] && win_base < win_next) begin
          win_base++;
          win_idle = '0;
          if (win_base >= win_total) end_transfer();
          else fill_window();
        end
      end
      FUNC_TICK: begin
        if (!win_done) begin
          limit = (win_timeout == 8'd0) ? 8'd1 : win_timeout;
          if (win_idle < IDLE_MAX) win_idle++;
          if (win_idle >= limit) begin
            for (i = win_base; i < win_next && emit_count < MAX_OUT; i++) emit_cmd(CMD_RESEND, i);
            win_idle = '0;
          end
        end
      end
      default: ;
    endcase
    if (emit_count > 0) pending_cmds[pending_cmds.size() - 1].last = 1'b1;
  endfunction

  task automatic send_item(func_e f, logic [7:0] flag, logic [7:0] seq);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    func_i     = f;
    ack_flag_i = flag;
    ack_seq_i  = seq;
    do @(posedge clk_i); while (!in_ready_o);
    window_step(f, flag, seq);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end
  endtask

  task automatic good_ack();
    send_item(FUNC_ACK, ACK_FLAG, win_base[7:0]);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == REG_TOTAL) win_total = value;
    else win_timeout = value[7:0];
  endtask

  task automatic test_before_start_and_empty();
    repeat (3) send_item(FUNC_TICK, 8'h00, 8'h00);
    send_item(FUNC_ACK, ACK_FLAG, 8'h00);
    send_item(FUNC_NONE, 8'hFF, 8'hFF);
    send_item(FUNC_START, 8'h00, 8'h00);
    send_item(FUNC_ACK, ACK_FLAG, 8'h00);
    send_item(FUNC_TICK, 8'hFF, 8'hFF);
  endtask

  task automatic test_window_and_timeout();
    write_reg(REG_TOTAL, 16'd3);
    write_reg(REG_TIMEOUT, 16'd1);
    send_item(FUNC_START, 8'h00, 8'h00);
    send_item(FUNC_ACK, 8'hFF, 8'h00);
    send_item(FUNC_ACK, ACK_FLAG, 8'hFF);
    send_item(FUNC_TICK, 8'h00, 8'h00);
    repeat (3) good_ack();
  endtask

  task automatic test_restart_and_shrink();
    write_reg(REG_TOTAL, 16'd20);
    write_reg(REG_TIMEOUT, 16'd0);
    send_item(FUNC_START, 8'h00, 8'h00);
    good_ack();
    send_item(FUNC_START, 8'h00, 8'h00);
    repeat (2) good_ack();
    write_reg(REG_TOTAL, 16'd1);
    send_item(FUNC_TICK, 8'h00, 8'h00);
    good_ack();
  endtask

  task automatic test_timeout_max();
    write_reg(REG_TOTAL, 16'd2);
    write_reg(REG_TIMEOUT, 16'd255);
    send_item(FUNC_START, 8'h00, 8'h00);
    repeat (12) send_item(FUNC_TICK, 8'($urandom), 8'($urandom));
  endtask

  task automatic test_long_transfer();
    write_reg(REG_TOTAL, 16'hFFFF);
    send_item(FUNC_START, 8'h00, 8'h00);
    repeat (12) good_ack();
  endtask

  task automatic test_random_traffic();
    int sent;
    int r;
    int len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      write_reg(REG_TOTAL, (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF :
                           (r == 2) ? 16'($urandom) : 16'($urandom_range(1, 12)));
      r = $urandom_range(0, 7);
      write_reg(REG_TIMEOUT, (r == 0) ? 16'd0 : (r == 1) ? 16'd255 :
                             (r == 2) ? 16'($urandom_range(0, 255)) : 16'($urandom_range(1, 4)));
      // sometimes keep the old transfer running under the new total
      if ($urandom_range(0, 4) != 0) send_item(FUNC_START, 8'($urandom), 8'($urandom));
      len = $urandom_range(8, 30);
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 60) good_ack();
        else if (r < 80) send_item(FUNC_TICK, 8'($urandom), 8'($urandom));
        else if (r < 90) send_item(FUNC_ACK, 8'($urandom), 8'($urandom));
        else if (r < 95) send_item(func_e'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
        else send_item(FUNC_START, 8'($urandom), 8'($urandom));
        if ($urandom_range(0, 24) == 0) wait_idle();
      end
      sent += len;
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_TOTAL;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    func_i      = FUNC_START;
    ack_flag_i  = '0;
    ack_seq_i   = '0;
    win_total   = '0;
    win_timeout = TIMEOUT_RST;
    win_base    = '0;
    win_next    = '0;
    win_idle    = '0;
    win_done    = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_before_start_and_empty();
    test_window_and_timeout();
    test_restart_and_shrink();
    test_timeout_max();
    test_long_transfer();
    test_random_traffic();

    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("sent %0d items and checked %0d commands", items_sent, cmds_seen);
    $display("covered empty, restarted and shrunk transfers, timeouts 0 to 255, random traffic");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

  // receiver stalls in modes that change at random: always ready, ready at random, or rarely ready
  initial begin
    int mode;
    int hold;
    out_ready_i = 1'b0;
    mode = 0;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold == 0) begin
        mode = $urandom_range(0, 2);
        hold = $urandom_range(10, 60);
      end
      hold--;
      case (mode)
        0: out_ready_i = 1'b1;
        1: out_ready_i = 1'($urandom_range(0, 1));
        default: out_ready_i = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cmd_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      cmds_seen++;
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected command %0d index %0d last %0d",
                   command_o, packet_index_o, last_o);
      end else begin
        want = pending_cmds.pop_front();
        if (command_o !== want.cmd || packet_index_o !== want.index || last_o !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected cmd %0d index %0d last %0d, got cmd %0d index %0d last %0d",
                     want.cmd, want.index, want.last, command_o, packet_index_o, last_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: nothing moved for %0d cycles, %0d commands outstanding",
                 stall_cycles, pending_cmds.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule
